>>> rtl/core/fbpa_pkg.sv
// Package: pool size, derived widths and the request and result beat types.
package fbpa_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int IDX_W      = (SLOT_COUNT > 2) ? $clog2(SLOT_COUNT) : 1;
    localparam int LINK_W     = $clog2(SLOT_COUNT + 1);
    localparam int COUNT_W    = $clog2(SLOT_COUNT + 1);

    // Fixed field widths of the ports
    localparam int SLOT_FIELD_W  = 4;
    localparam int COUNT_FIELD_W = 5;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOT_COUNT);

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                   kind;
        logic [SLOT_FIELD_W-1:0] slot_index;
    } req_t;

    typedef struct packed {
        logic                     granted;
        logic [SLOT_FIELD_W-1:0]  slot_given;
        logic                     was_busy;
        logic [COUNT_FIELD_W-1:0] in_use_count;
    } res_t;

endpackage

>>> rtl/core/fbpa_list.sv
// Linked slot list: link registers, busy marks, head, tail, count and update logic.
module fbpa_list (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  fbpa_pkg::req_t req,
    output fbpa_pkg::res_t res
);
    import fbpa_pkg::*;

    logic [LINK_W-1:0]  next_link_reg [SLOT_COUNT];
    logic [LINK_W-1:0]  prev_link_reg [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] busy_mark_reg;
    logic [IDX_W-1:0]   head_reg;
    logic [IDX_W-1:0]   tail_reg;
    logic [COUNT_W-1:0] count_reg;

    logic [LINK_W-1:0]  next_link_next [SLOT_COUNT];
    logic [LINK_W-1:0]  prev_link_next [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] busy_mark_next;
    logic [IDX_W-1:0]   head_next;
    logic [IDX_W-1:0]   tail_next;
    logic [COUNT_W-1:0] count_next;

    logic               slot_ok;
    logic [IDX_W-1:0]   s_idx;
    logic [LINK_W-1:0]  nx;
    logic [LINK_W-1:0]  pv;

    function automatic logic is_slot(input logic [LINK_W-1:0] l);
        return 32'(l) < SLOT_COUNT;
    endfunction

    assign slot_ok = 32'(req.slot_index) < SLOT_COUNT;
    assign s_idx   = IDX_W'(req.slot_index);

    // Apply writes in list order so that later writes win, as a sequential update would
    always_comb
    begin
        next_link_next = next_link_reg;
        prev_link_next = prev_link_reg;
        busy_mark_next = busy_mark_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        res            = '0;
        nx             = NULL_LINK;
        pv             = NULL_LINK;

        if (req.kind == KIND_ALLOC) begin
            if (!busy_mark_reg[head_reg]) begin
                busy_mark_next[head_reg] = 1'b1;
                count_next = count_reg + COUNT_W'(1);
                nx = next_link_reg[head_reg];
                if (is_slot(nx) && (head_reg != tail_reg)) begin
                    head_next = nx[IDX_W-1:0];
                    prev_link_next[nx[IDX_W-1:0]] = NULL_LINK;
                    next_link_next[tail_reg] = LINK_W'(head_reg);
                    next_link_next[head_reg] = NULL_LINK;
                    prev_link_next[head_reg] = LINK_W'(tail_reg);
                    tail_next = head_reg;
                end
                res.granted    = 1'b1;
                res.slot_given = SLOT_FIELD_W'(head_reg);
            end
        end else if (slot_ok) begin
            res.granted = 1'b1;
            if (busy_mark_reg[s_idx]) begin
                res.was_busy = 1'b1;
                if (count_reg != '0) begin
                    count_next = count_reg - COUNT_W'(1);
                end
            end
            busy_mark_next[s_idx] = 1'b0;
            pv = prev_link_reg[s_idx];
            nx = next_link_reg[s_idx];
            if (is_slot(pv) && (s_idx != head_reg)) begin
                if (!is_slot(nx)) begin
                    next_link_next[pv[IDX_W-1:0]] = NULL_LINK;
                    tail_next = pv[IDX_W-1:0];
                end else begin
                    next_link_next[pv[IDX_W-1:0]] = nx;
                    prev_link_next[nx[IDX_W-1:0]] = pv;
                end
                prev_link_next[s_idx]    = NULL_LINK;
                next_link_next[s_idx]    = LINK_W'(head_reg);
                prev_link_next[head_reg] = LINK_W'(s_idx);
                head_next = s_idx;
            end
        end

        res.in_use_count = COUNT_FIELD_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                next_link_reg[i] <= (i == 0) ? NULL_LINK : LINK_W'(i - 1);
                prev_link_reg[i] <= (i == SLOT_COUNT - 1) ? NULL_LINK : LINK_W'(i + 1);
            end
            busy_mark_reg <= '0;
            head_reg      <= IDX_W'(SLOT_COUNT - 1);
            tail_reg      <= '0;
            count_reg     <= '0;
        end else if (req_valid) begin
            next_link_reg <= next_link_next;
            prev_link_reg <= prev_link_next;
            busy_mark_reg <= busy_mark_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
        end
    end

endmodule

>>> rtl/core/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: request register, slot list, result register.
//
// Usage
//   Request channel: drive kind and slot_index with start high; the beat is
//   taken at any rising edge where start is high and busy is low. busy is
//   never raised, so a new request may be issued in every cycle.
//   kind selects allocate (slot_index ignored) or free of slot_index.
//   Result channel: done is high for exactly one cycle with granted,
//   slot_given, was_busy and in_use_count valid in that cycle.
//   The receiver cannot stall; each result beat must be taken when shown.
// Timing
//   A request is captured in the input register, then the list is
//   updated and the result registered at the following edge, with done
//   rising together with the result; the receiver takes the result beat
//   while done is high. Throughput is one request per cycle, since the
//   register-held link list is updated once per request; each request
//   sees the list as left by the one before it.
// Reset
//   rst_n clears the pipeline and restores the list to run from the highest
//   slot down to slot 0, all slots free, count zero. No clearing pass.
module fixed_block_pool_allocator (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  logic kind,
    input  logic [fbpa_pkg::SLOT_FIELD_W-1:0] slot_index,
    output logic done,
    output logic granted,
    output logic [fbpa_pkg::SLOT_FIELD_W-1:0] slot_given,
    output logic was_busy,
    output logic [fbpa_pkg::COUNT_FIELD_W-1:0] in_use_count
);
    import fbpa_pkg::*;

    logic req_valid_reg;
    req_t req_reg;
    res_t res_next;
    res_t res_reg;
    logic done_reg;
    logic accept;

    // The list takes a beat in every cycle, so never hold requests off
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Capture the request beat; payload needs no reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_valid_reg <= 1'b0;
        end else begin
            req_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            req_reg.kind       <= kind_t'(kind);
            req_reg.slot_index <= slot_index;
        end
    end

    fbpa_list u_list (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid_reg),
        .req       (req_reg),
        .res       (res_next)
    );

    // Register the result beat alongside the list update; strobe for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid_reg) begin
            res_reg <= res_next;
        end
    end

    assign done         = done_reg;
    assign granted      = res_reg.granted;
    assign slot_given   = res_reg.slot_given;
    assign was_busy     = res_reg.was_busy;
    assign in_use_count = res_reg.in_use_count;

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the fixed block pool allocator: directed and random beats.
import fbpa_pkg::*;

class slot_pool_ledger;

    typedef logic [LINK_W-1:0]        link_t;
    typedef logic [SLOT_FIELD_W-1:0]  slot_t;

    // Mirror of the slot list: free slots at the head, busy slots toward the tail
    link_t                next_slot [SLOT_COUNT];
    link_t                prev_slot [SLOT_COUNT];
    logic                 slot_taken [SLOT_COUNT];
    link_t                first_slot;
    link_t                last_slot;
    logic [COUNT_W-1:0]   taken_count;

    res_t                 awaited_results[$];
    int                   error_count;

    function void restore_list();
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            next_slot[i]  = (i == 0) ? NULL_LINK : link_t'(i - 1);
            prev_slot[i]  = (i + 1 < SLOT_COUNT) ? link_t'(i + 1) : NULL_LINK;
            slot_taken[i] = 1'b0;
        end
        first_slot     = link_t'(SLOT_COUNT - 1);
        last_slot      = '0;
        taken_count    = '0;
        awaited_results = {};
        error_count    = 0;
    endfunction

    function bit names_slot(link_t s);
        return s < link_t'(SLOT_COUNT);
    endfunction

    function int pending();
        return awaited_results.size();
    endfunction

    // Take the head slot if it is free and move it to the tail
    function void take_first(ref res_t r);
        link_t s;
        link_t nx;
        s = first_slot;
        if (!names_slot(s) || slot_taken[s])
            return;
        slot_taken[s] = 1'b1;
        taken_count   = taken_count + 1'b1;
        nx = next_slot[s];
        if (names_slot(nx) && s != last_slot)
        begin
            first_slot    = nx;
            prev_slot[nx] = NULL_LINK;
            if (names_slot(last_slot))
                next_slot[last_slot] = s;
            next_slot[s] = NULL_LINK;
            prev_slot[s] = last_slot;
            last_slot    = s;
        end
        r.granted    = 1'b1;
        r.slot_given = slot_t'(s);
    endfunction

    // Clear the busy mark and move the slot to the head
    function void release_slot(link_t s, ref res_t r);
        link_t pv;
        link_t nx;
        if (!names_slot(s))
            return;
        r.granted = 1'b1;
        if (slot_taken[s])
        begin
            r.was_busy = 1'b1;
            if (taken_count != 0)
                taken_count = taken_count - 1'b1;
        end
        slot_taken[s] = 1'b0;
        pv = prev_slot[s];
        if (!names_slot(pv) || s == first_slot)
            return;
        nx = next_slot[s];
        if (!names_slot(nx))
        begin
            next_slot[pv] = NULL_LINK;
            last_slot     = pv;
        end
        else
        begin
            next_slot[pv] = nx;
            prev_slot[nx] = pv;
        end
        prev_slot[s] = NULL_LINK;
        next_slot[s] = first_slot;
        if (names_slot(first_slot))
            prev_slot[first_slot] = s;
        first_slot = s;
    endfunction

    function void note_request(kind_t k, slot_t idx);
        res_t r;
        r = '0;
        if (k == KIND_ALLOC)
            take_first(r);
        else
            release_slot(link_t'(idx), r);
        r.in_use_count = COUNT_FIELD_W'(taken_count);
        awaited_results.push_back(r);
    endfunction

    function void check_result(logic g, slot_t sg, logic wb, logic [COUNT_FIELD_W-1:0] cnt);
        res_t r;
        if (awaited_results.size() == 0)
        begin
            $display("%0t: result beat with nothing awaited (granted %0b slot %0d)",
                     $time, g, sg);
            error_count++;
            return;
        end
        r = awaited_results.pop_front();
        if (g !== r.granted)
        begin
            $display("%0t: granted expected %0b actual %0b", $time, r.granted, g);
            error_count++;
        end
        if (sg !== r.slot_given)
        begin
            $display("%0t: slot_given expected %0d actual %0d", $time, r.slot_given, sg);
            error_count++;
        end
        if (wb !== r.was_busy)
        begin
            $display("%0t: was_busy expected %0b actual %0b", $time, r.was_busy, wb);
            error_count++;
        end
        if (cnt !== r.in_use_count)
        begin
            $display("%0t: in_use_count expected %0d actual %0d",
                     $time, r.in_use_count, cnt);
            error_count++;
        end
    endfunction

endclass

module tb_top;

    // Cycles without any beat on either side before the run is abandoned
    localparam int STALL_LIMIT = 4000;
    // Random beats per idling phase
    localparam int PHASE_BEATS = 432;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic                       kind = 1'b0;
    logic [SLOT_FIELD_W-1:0]    slot_index = '0;
    logic                       done;
    logic                       granted;
    logic [SLOT_FIELD_W-1:0]    slot_given;
    logic                       was_busy;
    logic [COUNT_FIELD_W-1:0]   in_use_count;

    slot_pool_ledger            ledger;
    int                         quiet_cycles = 0;

    fixed_block_pool_allocator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .slot_index   (slot_index),
        .done         (done),
        .granted      (granted),
        .slot_given   (slot_given),
        .was_busy     (was_busy),
        .in_use_count (in_use_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Check every result beat against the oldest prediction; the receiver
    // cannot hold results off, so each strobe is taken as it comes.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            ledger.check_result(granted, slot_given, was_busy, in_use_count);
    end

    // Watchdog: count cycles in which no beat moves on either channel.
    always @(posedge clk)
    begin
        if ((start && !busy) || done === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Issue one request beat. Hold start low for a random number of cycles
    // first, then hold the beat until the block takes it. The caller leaves
    // start high, so back-to-back beats never lower and raise it in one step.
    task automatic issue_request(input kind_t k, input logic [SLOT_FIELD_W-1:0] idx,
                                 input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        kind       <= k;
        slot_index <= idx;
        do
            @(posedge clk);
        while (busy);
        ledger.note_request(k, idx);
    endtask

    // Drop start and hold off until every awaited result has come back.
    task automatic drain_results();
        start <= 1'b0;
        while (ledger.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int idle_by_phase[4];
        int alloc_pct;
        kind_t k;

        ledger = new();
        ledger.restore_list();

        // Sender idling per phase; the receiver side cannot stall, so the
        // receiver-only phase runs with no gaps at all.
        idle_by_phase = '{0, 76, 0, 31};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Free the tail slot while it is still free: it moves
        // to the head with the count unchanged.
        issue_request(KIND_FREE, 4'd0, 0);
        // Free the head slot while free: only the busy mark is touched.
        issue_request(KIND_FREE, 4'd0, 0);
        // Free a free slot from the middle of the list.
        issue_request(KIND_FREE, 4'd9, 0);
        // Fill the pool, then allocate once more into a full pool.
        for (int n = 0; n < SLOT_COUNT; n++)
            issue_request(KIND_ALLOC, 4'd0, 0);
        issue_request(KIND_ALLOC, 4'hF, 0);
        // Free a busy slot, then free it again now that it sits at the head.
        issue_request(KIND_FREE, 4'd15, 0);
        issue_request(KIND_FREE, 4'd15, 0);
        // Reallocate it; it becomes the tail, then free the busy tail.
        issue_request(KIND_ALLOC, 4'd5, 0);
        issue_request(KIND_FREE, 4'd15, 0);
        issue_request(KIND_FREE, 4'd3, 0);
        drain_results();

        // Random part: the allocate share changes every few dozen beats so
        // the pool swings between empty and full, reaching both refusals and
        // frees of busy and free slots in every list position.
        alloc_pct = 50;
        foreach (idle_by_phase[p])
        begin
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                if (n % 40 == 0)
                begin
                    case ($urandom_range(2))
                        0:       alloc_pct = 20;
                        1:       alloc_pct = 55;
                        default: alloc_pct = 90;
                    endcase
                end
                k = ($urandom_range(99) < alloc_pct) ? KIND_ALLOC : KIND_FREE;
                issue_request(k, SLOT_FIELD_W'($urandom_range(15)), idle_by_phase[p]);
            end
            // Pause the sender until every awaited result is back.
            drain_results();
        end

        // Let the request and result registers empty before judging.
        repeat (4) @(posedge clk);
        if (ledger.error_count == 0 && ledger.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
